// ----- hw/rtl/sobol_pkg.sv -----
// Shared constants, codes and control types for the Sobol sequence generator.
package sobol_pkg;

  localparam int unsigned MaxDims    = 16;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned DimW       = $clog2(MaxDims);
  localparam int unsigned BitW       = $clog2(WordBits);
  localparam int unsigned AddrW      = DimW + BitW;
  localparam int unsigned TableDepth = MaxDims * WordBits;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned OpW        = 2;
  localparam int unsigned SampleW    = 32;

  typedef enum logic [OpW-1:0] {
    OpDraw    = 2'd0,
    OpLoad    = 2'd1,
    OpRestart = 2'd2,
    OpNop     = 2'd3
  } op_e;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic restart;
    logic draw_start;
    logic rd_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_dim;
  } status_t;

  typedef struct packed {
    logic [DimW-1:0]    dim_index;
    logic [SampleW-1:0] sample_value;
    logic               last_of_point;
    logic               exhausted;
  } rsp_t;

endpackage

// ----- hw/rtl/sobol_req_if.sv -----
// Request channel: opcode and direction table load fields.
interface sobol_req_if;
  logic                              valid;
  logic                              ready;
  logic [sobol_pkg::OpW-1:0]         opcode;
  logic [sobol_pkg::DimW-1:0]        dim_select;
  logic [sobol_pkg::BitW-1:0]        bit_select;
  logic [sobol_pkg::WordBits-1:0]    direction_word;

  modport source (output valid, opcode, dim_select, bit_select, direction_word, input ready);
  modport sink   (input valid, opcode, dim_select, bit_select, direction_word, output ready);
endinterface

// ----- hw/rtl/sobol_rsp_if.sv -----
// Result channel: one sample per transfer; a draw returns one per active dimension, 1 to 16.
interface sobol_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sobol_pkg::DimW-1:0]     dim_index;
  logic [sobol_pkg::SampleW-1:0]  sample_value;
  logic                           last_of_point;
  logic                           exhausted;

  modport source (output valid, dim_index, sample_value, last_of_point, exhausted, input ready);
  modport sink   (input valid, dim_index, sample_value, last_of_point, exhausted, output ready);
endinterface

// ----- hw/rtl/sobol_cfg_if.sv -----
// Configuration write channel: active dimension count.
interface sobol_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sobol_pkg::CfgW-1:0]  active_dimensions;

  modport source (output valid, active_dimensions, input ready);
  modport sink   (input valid, active_dimensions, output ready);
endinterface

// ----- hw/rtl/sobol_ctrl.sv -----
// Sequencer state machine: decodes requests and steps through the dimensions of a draw.
module sobol_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic [sobol_pkg::OpW-1:0]   req_opcode_i,
  output logic                        req_ready_o,
  input  sobol_pkg::status_t          status_i,
  output sobol_pkg::cmd_t             cmd_o
);

  sobol_pkg::state_e state_q, state_d;
  sobol_pkg::op_e    op;

  assign op = sobol_pkg::op_e'(req_opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sobol_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sobol_pkg::StIdle: begin
        if (req_valid_i && op == sobol_pkg::OpDraw) begin
          state_d = sobol_pkg::StRun;
        end
      end
      sobol_pkg::StRun: begin
        if (status_i.slot_free && status_i.last_dim) begin
          state_d = sobol_pkg::StIdle;
        end
      end
      default: state_d = sobol_pkg::StIdle;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      sobol_pkg::StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (op)
            sobol_pkg::OpDraw:    cmd_o.draw_start = 1'b1;
            sobol_pkg::OpLoad:    cmd_o.load       = 1'b1;
            sobol_pkg::OpRestart: cmd_o.restart    = 1'b1;
            default:              cmd_o            = '0;
          endcase
        end
      end
      sobol_pkg::StRun: begin
        if (status_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.rd_next = !status_i.last_dim;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hw/rtl/sobol_dp.sv -----
// Datapath: direction table, draw counter, per-dimension integers and result register.
module sobol_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sobol_pkg::cmd_t                   cmd_i,
  output sobol_pkg::status_t                status_o,
  input  logic [sobol_pkg::DimW-1:0]        dim_select_i,
  input  logic [sobol_pkg::BitW-1:0]        bit_select_i,
  input  logic [sobol_pkg::WordBits-1:0]    direction_word_i,
  input  logic                              cfg_valid_i,
  input  logic [sobol_pkg::CfgW-1:0]        cfg_data_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output sobol_pkg::rsp_t                   rsp_o
);

  logic [sobol_pkg::WordBits-1:0] mem_q [sobol_pkg::TableDepth];
  logic [sobol_pkg::WordBits-1:0] rd_q;
  logic [sobol_pkg::WordBits-1:0] counter_q;
  logic [sobol_pkg::WordBits-1:0] ints_q [sobol_pkg::MaxDims];
  logic [sobol_pkg::CfgW-1:0]     act_q;
  logic [sobol_pkg::BitW-1:0]     j_q, j_d;
  logic                           done_q, done_d;
  logic [sobol_pkg::DimW-1:0]     k_q, k_next, last_k;
  logic [sobol_pkg::AddrW-1:0]    raddr;
  logic                           rd_en;
  logic [sobol_pkg::WordBits-1:0] value_d;
  logic                           out_valid_q;
  sobol_pkg::rsp_t                out_q;

  // position of the lowest zero bit of the counter
  always_comb begin
    j_d = '0;
    for (int i = sobol_pkg::WordBits - 1; i >= 0; i--) begin
      if (!counter_q[i]) begin
        j_d = sobol_pkg::BitW'(i);
      end
    end
  end
  assign done_d = &counter_q;

  always_comb begin
    if (act_q == '0) begin
      last_k = '0;
    end else if (act_q > sobol_pkg::CfgW'(sobol_pkg::MaxDims)) begin
      last_k = sobol_pkg::DimW'(sobol_pkg::MaxDims - 1);
    end else begin
      last_k = sobol_pkg::DimW'(act_q - 1'b1);
    end
  end

  assign k_next = k_q + 1'b1;
  assign rd_en  = cmd_i.draw_start | cmd_i.rd_next;
  assign raddr  = cmd_i.draw_start ? {sobol_pkg::DimW'(0), j_d} : {k_next, j_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[{dim_select_i, bit_select_i}] <= direction_word_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign value_d = done_q ? ints_q[k_q] : (ints_q[k_q] ^ rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      act_q     <= sobol_pkg::CfgW'(1);
      j_q       <= '0;
      done_q    <= 1'b0;
      k_q       <= '0;
      for (int d = 0; d < sobol_pkg::MaxDims; d++) begin
        ints_q[d] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        act_q <= cfg_data_i;
      end
      if (cmd_i.restart) begin
        counter_q <= '0;
        for (int d = 0; d < sobol_pkg::MaxDims; d++) begin
          ints_q[d] <= '0;
        end
      end
      if (cmd_i.draw_start) begin
        j_q    <= j_d;
        done_q <= done_d;
        k_q    <= '0;
        if (!done_d) begin
          counter_q <= counter_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        ints_q[k_q] <= value_d;
        k_q         <= k_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.dim_index     <= k_q;
      out_q.sample_value  <= value_d;
      out_q.last_of_point <= (k_q == last_k);
      out_q.exhausted     <= done_q;
    end
  end

  assign status_o.slot_free = !out_valid_q | rsp_ready_i;
  assign status_o.last_dim  = (k_q == last_k);
  assign rsp_valid_o        = out_valid_q;
  assign rsp_o              = out_q;

endmodule

// ----- hw/rtl/sobol_sequence_generator.sv -----
// Top level of the Gray-code Sobol sequence generator.
//
//  channel | dir | fields                                          | handshake
//  req_i   | in  | opcode, dim_select, bit_select, direction_word  | valid/ready
//  rsp_o   | out | dim_index, sample_value, last_of_point, exhausted| valid/ready
//  cfg_i   | in  | active_dimensions                               | valid/ready
//
// Load, restart and unused requests are taken without leaving the idle state. A draw
// does one direction table read per returned component on its single port.
// Requests are taken only while the sequencer is idle; cfg_i is always ready.
// A stalled result holds the sequencer; the result register decouples the sides.
// Reset clears counter and integers at once; the direction table is undefined until loaded.
module sobol_sequence_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  sobol_req_if.sink   req_i,
  sobol_rsp_if.source rsp_o,
  sobol_cfg_if.sink   cfg_i
);

  sobol_pkg::cmd_t    cmd;
  sobol_pkg::status_t status;
  sobol_pkg::rsp_t    rsp;
  logic               rsp_valid;

  assign cfg_i.ready = 1'b1;

  sobol_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sobol_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .dim_select_i     (req_i.dim_select),
    .bit_select_i     (req_i.bit_select),
    .direction_word_i (req_i.direction_word),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_data_i       (cfg_i.active_dimensions),
    .rsp_valid_o      (rsp_valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_o            (rsp)
  );

  assign rsp_o.valid         = rsp_valid;
  assign rsp_o.dim_index     = rsp.dim_index;
  assign rsp_o.sample_value  = rsp.sample_value;
  assign rsp_o.last_of_point = rsp.last_of_point;
  assign rsp_o.exhausted     = rsp.exhausted;

endmodule

// ----- hw/rtl/sobol_checker.sv -----
// Port-level checks for the Sobol sequence generator, bound to the top level.
module sobol_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [sobol_pkg::OpW-1:0]      req_opcode_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [sobol_pkg::DimW-1:0]     rsp_dim_index_i,
  input logic [sobol_pkg::SampleW-1:0]  rsp_sample_value_i,
  input logic                           rsp_last_of_point_i
);

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // a draw takes the sequencer out of idle, so the request channel drops ready
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_opcode_i == sobol_pkg::OpDraw |=> !req_ready_i)
    else $error("request taken right after a draw");

  // after a non-draw request the request channel is ready again in the next cycle
  a_other_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_opcode_i != sobol_pkg::OpDraw |=> req_ready_i)
    else $error("load or restart stalled the request channel");

  // the highest dimension always closes a point
  a_top_dim_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_dim_index_i == sobol_pkg::DimW'(sobol_pkg::MaxDims - 1)
    |-> rsp_last_of_point_i)
    else $error("top dimension without last_of_point");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_sample_value_i)
    && $stable(rsp_dim_index_i))
    else $error("stalled result changed");

endmodule

bind sobol_sequence_generator sobol_checker u_sobol_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .req_opcode_i        (req_i.opcode),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_dim_index_i     (rsp_o.dim_index),
  .rsp_sample_value_i  (rsp_o.sample_value),
  .rsp_last_of_point_i (rsp_o.last_of_point)
);
